// ===== hw/rtl/att_pkg.sv =====
// Shared types, character codes and classing functions for the assembly tokeniser.
// No dependencies; used by every module of the block.
`default_nettype none

package att_pkg;

	// Scan state held between items
	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_NEWLINE = 3'd1,
		ST_COMMENT = 3'd2,
		ST_STRING  = 3'd3,
		ST_SYMBOL  = 3'd4
	} scan_state_t;

	// Token kinds
	localparam logic [3:0] KIND_NEWLINE = 4'd0;
	localparam logic [3:0] KIND_PLUS    = 4'd1;
	localparam logic [3:0] KIND_MINUS   = 4'd2;
	localparam logic [3:0] KIND_LPAREN  = 4'd3;
	localparam logic [3:0] KIND_RPAREN  = 4'd4;
	localparam logic [3:0] KIND_DOT     = 4'd5;
	localparam logic [3:0] KIND_COMMA   = 4'd6;
	localparam logic [3:0] KIND_COLON   = 4'd7;
	localparam logic [3:0] KIND_COMMENT = 4'd8;
	localparam logic [3:0] KIND_EOF     = 4'd9;
	localparam logic [3:0] KIND_SYMBOL  = 4'd10;
	localparam logic [3:0] KIND_SKIPPED = 4'd11;

	// Input mode
	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_END  = 1'b1;

	// Character codes
	localparam logic [7:0] CH_NUL    = 8'd0;
	localparam logic [7:0] CH_ETX    = 8'd3;
	localparam logic [7:0] CH_TAB    = 8'd9;
	localparam logic [7:0] CH_LF     = 8'd10;
	localparam logic [7:0] CH_CR     = 8'd13;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_QUOTE  = 8'd34;
	localparam logic [7:0] CH_HASH   = 8'd35;
	localparam logic [7:0] CH_DOLLAR = 8'd36;
	localparam logic [7:0] CH_APOS   = 8'd39;
	localparam logic [7:0] CH_LPAREN = 8'd40;
	localparam logic [7:0] CH_RPAREN = 8'd41;
	localparam logic [7:0] CH_PLUS   = 8'd43;
	localparam logic [7:0] CH_COMMA  = 8'd44;
	localparam logic [7:0] CH_MINUS  = 8'd45;
	localparam logic [7:0] CH_DOT    = 8'd46;
	localparam logic [7:0] CH_DIG_LO = 8'd48;
	localparam logic [7:0] CH_DIG_HI = 8'd57;
	localparam logic [7:0] CH_COLON  = 8'd58;
	localparam logic [7:0] CH_SEMI   = 8'd59;
	localparam logic [7:0] CH_UC_LO  = 8'd65;
	localparam logic [7:0] CH_UC_HI  = 8'd90;
	localparam logic [7:0] CH_UNDER  = 8'd95;
	localparam logic [7:0] CH_BTICK  = 8'd96;
	localparam logic [7:0] CH_LC_LO  = 8'd97;
	localparam logic [7:0] CH_LC_HI  = 8'd122;

	// Item types
	typedef struct packed {
		logic       mode;
		logic [7:0] source_byte;
	} src_item_t;

	typedef struct packed {
		logic [3:0] token_kind;
		logic       token_start;
		logic [7:0] literal_byte;
		logic       byte_kept;
	} tok_item_t;

	function automatic logic is_line_break(input logic [7:0] c);
		return (c == CH_CR) || (c == CH_LF) || (c == CH_SEMI);
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	function automatic logic is_symbol_char(input logic [7:0] c);
		logic alpha;
		logic digit;
		logic extra;
		alpha = ((c >= CH_UC_LO) && (c <= CH_UC_HI)) || ((c >= CH_LC_LO) && (c <= CH_LC_HI));
		digit = (c >= CH_DIG_LO) && (c <= CH_DIG_HI);
		extra = (c == CH_DOLLAR) || (c == CH_APOS) || (c == CH_DOT) ||
			(c == CH_UNDER) || (c == CH_BTICK);
		return alpha || digit || extra;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/att_classify.sv =====
// Combinational byte classifier: result item and next scan state for one item.
// Depends on att_pkg.
`default_nettype none

module att_classify
	import att_pkg::*;
(
	input  src_item_t   item,
	input  scan_state_t state,
	output tok_item_t   result,
	output scan_state_t state_nxt
);

	logic [7:0]  c;
	tok_item_t   idle_res;
	scan_state_t idle_nxt;

	assign c = item.source_byte;

	// Classification with no token open
	always_comb begin
		idle_nxt              = ST_IDLE;
		idle_res.token_start  = 1'b1;
		idle_res.literal_byte = c;
		idle_res.byte_kept    = 1'b1;
		idle_res.token_kind   = KIND_SYMBOL;
		if (is_blank(c)) begin
			idle_res.token_kind  = KIND_SKIPPED;
			idle_res.token_start = 1'b0;
			idle_res.byte_kept   = 1'b0;
		end else if (is_line_break(c)) begin
			idle_res.token_kind = KIND_NEWLINE;
			idle_nxt            = ST_NEWLINE;
		end else begin
			unique case (c)
				CH_PLUS:   idle_res.token_kind = KIND_PLUS;
				CH_MINUS:  idle_res.token_kind = KIND_MINUS;
				CH_LPAREN: idle_res.token_kind = KIND_LPAREN;
				CH_RPAREN: idle_res.token_kind = KIND_RPAREN;
				CH_DOT:    idle_res.token_kind = KIND_DOT;
				CH_COMMA:  idle_res.token_kind = KIND_COMMA;
				CH_COLON:  idle_res.token_kind = KIND_COLON;
				CH_HASH: begin
					idle_res.token_kind = KIND_COMMENT;
					idle_nxt            = ST_COMMENT;
				end
				CH_NUL, CH_ETX: idle_res.token_kind = KIND_EOF;
				CH_QUOTE: begin
					idle_res.token_kind = KIND_SYMBOL;
					idle_nxt            = ST_STRING;
				end
				default: begin
					idle_res.token_kind = KIND_SYMBOL;
					idle_nxt            = ST_SYMBOL;
				end
			endcase
		end
	end

	// End-of-input marker, continuation of an open token, else fall back to idle classification
	always_comb begin
		result    = idle_res;
		state_nxt = idle_nxt;
		if (item.mode == MODE_END) begin
			result.token_kind   = KIND_EOF;
			result.token_start  = 1'b1;
			result.literal_byte = CH_ETX;
			result.byte_kept    = 1'b1;
			state_nxt           = ST_IDLE;
		end else begin
			unique case (state)
				ST_NEWLINE: begin
					if (is_line_break(c) || is_blank(c)) begin
						result.token_kind  = KIND_NEWLINE;
						result.token_start = 1'b0;
						result.byte_kept   = 1'b0;
						state_nxt          = ST_NEWLINE;
					end
				end
				ST_COMMENT: begin
					if (!is_line_break(c)) begin
						result.token_kind  = KIND_COMMENT;
						result.token_start = 1'b0;
						result.byte_kept   = 1'b1;
						state_nxt          = ST_COMMENT;
					end
				end
				ST_STRING: begin
					result.token_kind  = KIND_SYMBOL;
					result.token_start = 1'b0;
					result.byte_kept   = 1'b1;
					state_nxt          = (c == CH_QUOTE) ? ST_IDLE : ST_STRING;
				end
				ST_SYMBOL: begin
					if (is_symbol_char(c)) begin
						result.token_kind  = KIND_SYMBOL;
						result.token_start = 1'b0;
						result.byte_kept   = 1'b1;
						state_nxt          = ST_SYMBOL;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/assembly_text_tokenizer.sv =====
// Assembly source tokeniser: input register, classifier, scan state and result register.
// Depends on att_pkg and att_classify.
//
// Usage:
//   src channel (src_valid/src_ready/src_item) takes one item per cycle unless stalled:
//   a source byte (mode 0) or an end-of-input marker (mode 1).
//   tok channel (tok_valid/tok_ready/tok_item) returns exactly one tagged item
//   per input item, in order: token kind, token start, the byte, and whether
//   it is kept in the token text.
//   An accepted item goes from the input register through the classifier into
//   the result register when that register is empty or being drained, and is
//   shown on tok_item from then on.
//   Throughput: one item per cycle while tok_ready stays high; the only loop
//   is the 3-bit scan state fed back through the classifier.
//   Reset (arst_n low, asynchronous) empties both registers and sets the scan
//   state to idle between tokens.
//   When the receiver stalls, the result register holds its item, the input
//   register still accepts one more item, and src_ready then drops until the
//   result is taken. No item is lost or repeated.
`default_nettype none

module assembly_text_tokenizer
	import att_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      src_valid,
	output      logic      src_ready,
	input  wire src_item_t src_item,
	output      logic      tok_valid,
	input  wire logic      tok_ready,
	output      tok_item_t tok_item
);

	logic        valid_s1;
	src_item_t   item_s1;
	logic        valid_s2;
	tok_item_t   item_s2;
	scan_state_t state_q;
	scan_state_t state_nxt;
	tok_item_t   result;
	logic        advance;

	// Stage 1 moves on when the result register is empty or being drained
	assign advance   = valid_s1 && (!valid_s2 || tok_ready);
	assign src_ready = !valid_s1 || advance;

	att_classify u_classify (
		.item      (item_s1),
		.state     (state_q),
		.result    (result),
		.state_nxt (state_nxt)
	);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= ST_IDLE;
		end else begin
			if (src_ready) begin
				valid_s1 <= src_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (tok_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (src_ready && src_valid) begin
			item_s1 <= src_item;
		end
		if (advance) begin
			item_s2 <= result;
		end
	end

	assign tok_valid = valid_s2;
	assign tok_item  = item_s2;

endmodule

`default_nettype wire

// ===== hw/rtl/att_checker.sv =====
// Port-level checks for the assembly tokeniser, bound to the top level.
// Depends on att_pkg and assembly_text_tokenizer.
`default_nettype none

module att_checker
	import att_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      src_valid,
	input wire logic      src_ready,
	input wire src_item_t src_item,
	input wire logic      tok_valid,
	input wire logic      tok_ready,
	input wire tok_item_t tok_item
);

	// A stalled result item holds still
	assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> tok_valid && $stable(tok_item))
		else $error("result item changed while stalled");

	// An end-of-input item accepted while the output is free comes out as a kept eof
	// token through the input and result registers if the output is then drained
	assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_ready && (src_item.mode == MODE_END) && !tok_valid
		##1 tok_ready |=> tok_valid && (tok_item.token_kind == KIND_EOF) &&
		tok_item.token_start && tok_item.byte_kept && (tok_item.literal_byte == CH_ETX))
		else $error("end of input not turned into eof token");

	// Skipped blanks never start a token nor enter its text
	assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (tok_item.token_kind == KIND_SKIPPED) |->
		!tok_item.token_start && !tok_item.byte_kept)
		else $error("skipped byte marked as token text");

	// Every token start is kept in the token text
	assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_item.token_start |-> tok_item.byte_kept)
		else $error("token start not kept");

endmodule

bind assembly_text_tokenizer att_checker u_att_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_valid (src_valid),
	.src_ready (src_ready),
	.src_item  (src_item),
	.tok_valid (tok_valid),
	.tok_ready (tok_ready),
	.tok_item  (tok_item)
);

`default_nettype wire
